@@ design/wtrms_pkg.sv @@
// wtrms_pkg: shared constants, register codes and config struct for the
// windowed true-RMS meter. No dependencies.
package wtrms_pkg;

    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_SUM_BITS    = 40;

    localparam int CFG_BITS = 16;
    localparam int IDX_BITS = 2;
    localparam int WIN_BITS = 7;
    localparam int RMS_BITS = 16;

    localparam logic [IDX_BITS-1:0] REG_SCALE  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_OFFSET = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_WINDOW = 2'd2;

    localparam logic [CFG_BITS-1:0] SCALE_RESET  = 16'd8057;
    localparam logic [CFG_BITS-1:0] OFFSET_RESET = 16'd0;
    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 7'd20;

    // mv = floor(prod / 10000) as (prod * MV_RECIP) >> MV_SHIFT, exact for 32-bit prod
    localparam longint unsigned MV_DIVISOR = 10000;
    localparam int              MV_SHIFT   = 45;
    localparam logic [31:0]     MV_RECIP   =
        32'(((64'd1 << MV_SHIFT) + MV_DIVISOR - 64'd1) / MV_DIVISOR);

    typedef struct packed {
        logic [CFG_BITS-1:0] scale_factor;
        logic [CFG_BITS-1:0] offset_mv;
        logic [WIN_BITS-1:0] window_length;
    } cfg_t;

endpackage

@@ design/wtrms_front.sv @@
// wtrms_front: sample pipeline (scale, offset, square) and saturating window
// accumulator; pushes finished window sums. Depends on wtrms_pkg.
module wtrms_front #(
    parameter int SAMPLE_BITS = wtrms_pkg::DEF_SAMPLE_BITS,
    parameter int SUM_BITS    = wtrms_pkg::DEF_SUM_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wtrms_pkg::cfg_t               cfg,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [SAMPLE_BITS-1:0]        adc_sample,
    input  logic                          q_full,
    output logic                          push,
    output logic [SUM_BITS-1:0]           push_sum,
    output logic [wtrms_pkg::WIN_BITS-1:0] push_win
);
    import wtrms_pkg::*;

    localparam int PROD_BITS = SAMPLE_BITS + CFG_BITS;
    localparam int QW_BITS   = PROD_BITS + 32;
    localparam int MV_BITS   = SAMPLE_BITS + 3;
    localparam int MAG_BITS  = (MV_BITS > CFG_BITS) ? MV_BITS : CFG_BITS;
    localparam int SQ_BITS   = 2 * MAG_BITS;
    localparam int ACC_BITS  = ((SUM_BITS > SQ_BITS) ? SUM_BITS : SQ_BITS) + 1;

    logic                 advance;
    logic [3:0]           vld_reg;
    logic [PROD_BITS-1:0] prod_reg;
    logic [MV_BITS-1:0]   mv_reg;
    logic [MAG_BITS-1:0]  mag_reg;
    logic [SQ_BITS-1:0]   sq_reg;
    logic [SUM_BITS-1:0]  sum_reg;
    logic [SUM_BITS-1:0]  sum_next;
    logic [WIN_BITS-1:0]  count_reg;
    logic [WIN_BITS-1:0]  count_next;

    logic [QW_BITS-1:0]   qwide;
    logic [MAG_BITS-1:0]  mv_ext;
    logic [MAG_BITS-1:0]  off_ext;
    logic [ACC_BITS-1:0]  total;
    logic [SUM_BITS-1:0]  acc_sum;
    logic [WIN_BITS-1:0]  cnt1;
    logic [WIN_BITS-1:0]  win;
    logic                 win_end;

    assign advance  = !q_full;
    assign in_stall = q_full;

    assign qwide   = QW_BITS'(prod_reg) * QW_BITS'(MV_RECIP);
    assign mv_ext  = MAG_BITS'(mv_reg);
    assign off_ext = MAG_BITS'(cfg.offset_mv);

    assign total   = ACC_BITS'(sum_reg) + ACC_BITS'(sq_reg);
    assign acc_sum = (total > ACC_BITS'({SUM_BITS{1'b1}})) ? {SUM_BITS{1'b1}}
                                                           : total[SUM_BITS-1:0];
    assign cnt1    = count_reg + WIN_BITS'(1);
    assign win     = (cfg.window_length == '0) ? WIN_BITS'(1) : cfg.window_length;
    assign win_end = (cnt1 >= win);

    assign push     = vld_reg[3] && advance && win_end;
    assign push_sum = acc_sum;
    assign push_win = win;

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (vld_reg[3] && advance)
        begin
            if (win_end)
            begin
                sum_next   = '0;
                count_next = '0;
            end
            else
            begin
                sum_next   = acc_sum;
                count_next = cnt1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            if (advance)
            begin
                vld_reg <= {vld_reg[2:0], in_valid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg <= PROD_BITS'(adc_sample) * PROD_BITS'(cfg.scale_factor);
            mv_reg   <= qwide[MV_SHIFT +: MV_BITS];
            mag_reg  <= (mv_ext >= off_ext) ? (mv_ext - off_ext) : (off_ext - mv_ext);
            sq_reg   <= SQ_BITS'(mag_reg) * SQ_BITS'(mag_reg);
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != {WIN_BITS{1'b1}})
        else $error("window count reached its wrap value");

endmodule

@@ design/wtrms_queue.sv @@
// wtrms_queue: two-entry FIFO carrying window sums and lengths from front to back.
// Depends on wtrms_pkg only through its users.
module wtrms_queue #(
    parameter int DATA_BITS = 47
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    input  logic                 pop,
    output logic [DATA_BITS-1:0] pop_data,
    output logic                 full,
    output logic                 empty
);
    logic [DATA_BITS-1:0] mem_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           fill_reg;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("push into full queue");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

@@ design/wtrms_back.sv @@
// wtrms_back: bit-serial restoring divide of the window sum by its length,
// then digit-by-digit floor square root, result register. Depends on wtrms_pkg.
module wtrms_back #(
    parameter int SUM_BITS = wtrms_pkg::DEF_SUM_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_empty,
    input  logic [SUM_BITS-1:0]            q_sum,
    input  logic [wtrms_pkg::WIN_BITS-1:0] q_win,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [wtrms_pkg::RMS_BITS-1:0] rms_value
);
    import wtrms_pkg::*;

    localparam int ROOT_BITS = (SUM_BITS + 1) / 2;
    localparam int ROOT_IN   = 2 * ROOT_BITS;
    localparam int RR_BITS   = ROOT_BITS + 2;
    localparam int CNT_BITS  = $clog2(SUM_BITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [CNT_BITS-1:0]  cnt_next;

    logic [SUM_BITS-1:0]  dq_reg;
    logic [WIN_BITS-1:0]  win_reg;
    logic [WIN_BITS-1:0]  rem_reg;
    logic [ROOT_IN-1:0]   rop_reg;
    logic [RR_BITS-1:0]   rr_reg;
    logic [ROOT_BITS-1:0] root_reg;
    logic [RMS_BITS-1:0]  rms_reg;

    logic [WIN_BITS:0]    rem_sh;
    logic [WIN_BITS:0]    rem_sub;
    logic                 q_bit;
    logic [SUM_BITS-1:0]  dq_next;
    logic [WIN_BITS-1:0]  rem_next;

    logic [RR_BITS-1:0]   rr_sh;
    logic [RR_BITS-1:0]   trial;
    logic                 r_bit;
    logic [RR_BITS-1:0]   rr_next;
    logic [ROOT_BITS-1:0] root_next;
    logic [RMS_BITS-1:0]  rms_sat;

    assign pop       = (state_reg == ST_IDLE) && !q_empty;
    assign out_valid = (state_reg == ST_DONE);
    assign rms_value = rms_reg;

    assign rem_sh   = {rem_reg, dq_reg[SUM_BITS-1]};
    assign q_bit    = (rem_sh >= {1'b0, win_reg});
    assign rem_sub  = rem_sh - {1'b0, win_reg};
    assign rem_next = q_bit ? rem_sub[WIN_BITS-1:0] : rem_sh[WIN_BITS-1:0];
    assign dq_next  = {dq_reg[SUM_BITS-2:0], q_bit};

    assign rr_sh     = {rr_reg[RR_BITS-3:0], rop_reg[ROOT_IN-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign r_bit     = (rr_sh >= trial);
    assign rr_next   = r_bit ? (rr_sh - trial) : rr_sh;
    assign root_next = {root_reg[ROOT_BITS-2:0], r_bit};
    assign rms_sat   = (root_next > ROOT_BITS'({RMS_BITS{1'b1}})) ? {RMS_BITS{1'b1}}
                                                                 : root_next[RMS_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(SUM_BITS - 1))
                begin
                    state_next = ST_ROOT;
                    cnt_next   = '0;
                end
            end
            ST_ROOT:
            begin
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(ROOT_BITS - 1))
                begin
                    state_next = ST_DONE;
                    cnt_next   = '0;
                end
            end
            ST_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dq_reg  <= q_sum;
                win_reg <= q_win;
                rem_reg <= '0;
            end
            ST_DIV:
            begin
                dq_reg  <= dq_next;
                rem_reg <= rem_next;
                if (cnt_reg == CNT_BITS'(SUM_BITS - 1))
                begin
                    rop_reg  <= ROOT_IN'(dq_next);
                    rr_reg   <= '0;
                    root_reg <= '0;
                end
            end
            ST_ROOT:
            begin
                rop_reg  <= {rop_reg[ROOT_IN-3:0], 2'b00};
                rr_reg   <= rr_next;
                root_reg <= root_next;
                if (cnt_reg == CNT_BITS'(ROOT_BITS - 1))
                begin
                    rms_reg <= rms_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (win_reg != '0))
        else $error("divide by zero window");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < win_reg))
        else $error("divider remainder out of range");

    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT) |-> (rr_reg <= RR_BITS'({root_reg, 1'b0})))
        else $error("root remainder exceeds twice the partial root");

endmodule

@@ design/windowed_true_rms_meter_top.sv @@
// windowed_true_rms_meter_top: config registers and the front/queue/back
// split of the true-RMS meter. Depends on wtrms_pkg, wtrms_front,
// wtrms_queue, wtrms_back.
//
// Usage: one converter reading per input beat (in_valid/in_stall,
// adc_sample). Each reading is scaled to mV, offset-corrected, squared and
// accumulated. After window_length readings one rms_value beat is offered
// on out_valid/out_stall; other readings give no output.
// Input: one beat per cycle while the two-entry window queue has room; a
// reading passes the product, mV, magnitude and square registers before
// it is added to the window sum. Output: the back unit divides one bit
// per cycle across the SUM_BITS-bit window sum, then takes one root digit
// per cycle for a root of SUM_BITS/2 rounded up bits, and takes a new
// window from the queue only when idle, once the last result is taken.
// While out_stall is high the result holds; the back unit waits, the queue
// fills, and in_stall rises once two further windows are queued.
// Reset clears the accumulator, counter, queue and back unit and loads
// scale 8057, offset 0, window 20. The user must write config through
// wr_en/wr_index/wr_data while the block is idle; the block does not check.
module windowed_true_rms_meter_top #(
    parameter int SAMPLE_BITS = wtrms_pkg::DEF_SAMPLE_BITS,
    parameter int SUM_BITS    = wtrms_pkg::DEF_SUM_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [wtrms_pkg::IDX_BITS-1:0] wr_index,
    input  logic [wtrms_pkg::CFG_BITS-1:0] wr_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [SAMPLE_BITS-1:0]         adc_sample,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [wtrms_pkg::RMS_BITS-1:0] rms_value
);
    import wtrms_pkg::*;

    localparam int Q_BITS = SUM_BITS + WIN_BITS;

    cfg_t                cfg_reg;
    logic                push;
    logic [SUM_BITS-1:0] push_sum;
    logic [WIN_BITS-1:0] push_win;
    logic                pop;
    logic [Q_BITS-1:0]   pop_data;
    logic                q_full;
    logic                q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_factor  <= SCALE_RESET;
            cfg_reg.offset_mv     <= OFFSET_RESET;
            cfg_reg.window_length <= WINDOW_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SCALE:  cfg_reg.scale_factor  <= wr_data;
                REG_OFFSET: cfg_reg.offset_mv     <= wr_data;
                REG_WINDOW: cfg_reg.window_length <= wr_data[WIN_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    wtrms_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .q_full     (q_full),
        .push       (push),
        .push_sum   (push_sum),
        .push_win   (push_win)
    );

    wtrms_queue #(
        .DATA_BITS (Q_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_sum, push_win}),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    wtrms_back #(
        .SUM_BITS (SUM_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_sum     (pop_data[Q_BITS-1:WIN_BITS]),
        .q_win     (pop_data[WIN_BITS-1:0]),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rms_value (rms_value)
    );

endmodule

@@ dv/windowed_true_rms_meter_top_test.sv @@
// Self-checking testbench for windowed_true_rms_meter_top: directed and random
// sample streams against a bit-exact RMS predictor, random input gaps, output stalls.
// Depends on wtrms_pkg and the design sources under design/.
module windowed_true_rms_meter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import wtrms_pkg::*;

    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int SUM_BITS    = DEF_SUM_BITS;
    localparam int ITEMS       = 1900;
    localparam int CALM_ITEMS  = 300;
    localparam int SETTLE_CYC  = 100;
    localparam int HOLD_CYC    = 800;
    localparam int LIMIT       = 1000000;

    localparam logic [IDX_BITS-1:0] REG_UNUSED = 2'd3;

    class rms_predictor;
        logic [CFG_BITS-1:0] scale;
        logic [CFG_BITS-1:0] offset;
        logic [WIN_BITS-1:0] window;
        logic [SUM_BITS-1:0] sq_sum;
        logic [WIN_BITS-1:0] n_samples;
        logic [RMS_BITS-1:0] expected_rms[$];
        int errors;

        function new();
            scale     = SCALE_RESET;
            offset    = OFFSET_RESET;
            window    = WINDOW_RESET;
            sq_sum    = '0;
            n_samples = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
            case (idx)
                REG_SCALE:  scale  = val;
                REG_OFFSET: offset = val;
                REG_WINDOW: window = val[WIN_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [RMS_BITS-1:0] root_of_mean(logic [SUM_BITS-1:0] v);
            logic [31:0] r;
            logic [31:0] t;
            r = '0;
            for (int b = SUM_BITS / 2; b >= 0; b--)
            begin
                t = r | (32'd1 << b);
                if (64'(t) * 64'(t) <= 64'(v))
                    r = t;
            end
            return (r > 32'hFFFF) ? 16'hFFFF : r[15:0];
        endfunction

        function void take_sample(logic [SAMPLE_BITS-1:0] s);
            logic [27:0]         prod;
            logic [15:0]         mv;
            logic [15:0]         mag;
            logic [31:0]         sq;
            logic [SUM_BITS:0]   acc;
            logic [WIN_BITS-1:0] win;
            prod = s * scale;
            mv   = 16'(prod / 28'd10000);
            mag  = (mv >= offset) ? mv - offset : offset - mv;
            sq   = mag * mag;
            acc  = {1'b0, sq_sum} + sq;
            sq_sum = acc[SUM_BITS] ? {SUM_BITS{1'b1}} : acc[SUM_BITS-1:0];
            n_samples = n_samples + 1'b1;
            win = (window == 0) ? 7'd1 : window;
            if (n_samples >= win)
            begin
                expected_rms.push_back(root_of_mean(sq_sum / win));
                sq_sum    = '0;
                n_samples = '0;
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        task check_rms(logic [RMS_BITS-1:0] got);
            logic [RMS_BITS-1:0] want;
            if (expected_rms.size() == 0)
                report($sformatf("rms_value %0d with no result pending", got));
            else
            begin
                want = expected_rms.pop_front();
                if (got !== want)
                    report($sformatf("rms_value got %0d exp %0d", got, want));
            end
        endtask

        function int pending();
            return expected_rms.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [IDX_BITS-1:0]    wr_index;
    logic [CFG_BITS-1:0]    wr_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [RMS_BITS-1:0]    rms_value;

    rms_predictor sb;
    bit idle_on;
    bit hold_req;
    int samples_sent;
    int cycles;

    windowed_true_rms_meter_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .adc_sample (adc_sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .rms_value  (rms_value)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // receiver: random short stalls, plus one long hold-off on request
    initial
    begin
        int hold_cnt;
        int burst_cnt;
        hold_cnt  = 0;
        burst_cnt = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_CYC;
            end
            if (hold_cnt > 0)
            begin
                out_stall <= 1'b1;
                hold_cnt--;
            end
            else if (burst_cnt > 0)
            begin
                out_stall <= 1'b1;
                burst_cnt--;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                burst_cnt = $urandom_range(0, 2);
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_rms(rms_value);

    function automatic logic [SAMPLE_BITS-1:0] gen_sample();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return SAMPLE_BITS'($urandom_range(2040, 2056));
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] v);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        adc_sample <= v;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.take_sample(v);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // partial windows still sit in the front pipeline after the last result
    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    initial
    begin
        int nwin;
        int count;
        bit pressure_done;
        logic [CFG_BITS-1:0] val;

        sb = new();
        rst_n        = 1'b0;
        wr_en        = 1'b0;
        wr_index     = REG_SCALE;
        wr_data      = '0;
        in_valid     = 1'b0;
        adc_sample   = '0;
        idle_on      = 1'b1;
        hold_req     = 1'b0;
        samples_sent = 0;
        pressure_done = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, left mid-window
        repeat (5) send_sample(gen_sample());
        drain_block();

        // zero window acts as one; widest scale
        write_reg(REG_WINDOW, 16'h0000);
        write_reg(REG_SCALE, 16'hFFFF);
        write_reg(REG_OFFSET, 16'h0000);
        send_sample(12'h000);
        send_sample(12'hFFF);
        drain_block();

        // offset above every scaled reading
        write_reg(REG_OFFSET, 16'hFFFF);
        send_sample(12'hFFF);
        send_sample(12'h000);
        drain_block();

        // unused index ignored; high window bits dropped
        write_reg(REG_UNUSED, 16'h5A5A);
        write_reg(REG_WINDOW, 16'hFF83);
        write_reg(REG_SCALE, 16'd12345);
        write_reg(REG_OFFSET, 16'd1000);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'h7FF);
        drain_block();

        // window shortened below the current count
        write_reg(REG_WINDOW, 16'd10);
        repeat (5) send_sample(gen_sample());
        drain_block();
        write_reg(REG_WINDOW, 16'd2);
        send_sample(gen_sample());
        drain_block();

        while (samples_sent < ITEMS)
        begin
            if (samples_sent >= ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            if (!pressure_done && samples_sent >= 800)
            begin
                write_reg(REG_WINDOW, 16'd3);
                hold_req = 1'b1;
                repeat (120) send_sample(gen_sample());
                drain_block();
                pressure_done = 1'b1;
            end

            case ($urandom_range(0, 5))
                0:       write_reg(REG_SCALE, SCALE_RESET);
                1:       write_reg(REG_SCALE, 16'h0000);
                2:       write_reg(REG_SCALE, 16'hFFFF);
                3:       write_reg(REG_SCALE, CFG_BITS'($urandom));
                default: ;
            endcase
            case ($urandom_range(0, 6))
                0:       write_reg(REG_OFFSET, 16'h0000);
                1:       write_reg(REG_OFFSET, 16'hFFFF);
                2:       write_reg(REG_OFFSET, CFG_BITS'($urandom_range(0, 27000)));
                3:       write_reg(REG_OFFSET, CFG_BITS'($urandom_range(1500, 1800)));
                default: ;
            endcase
            if ($urandom_range(0, 9) == 0)
                write_reg(REG_UNUSED, CFG_BITS'($urandom));

            case ($urandom_range(0, 19))
                0:       nwin = 0;
                1:       nwin = 1;
                2:       nwin = 64;
                3:       nwin = $urandom_range(65, 127);
                4:       nwin = 127;
                default: nwin = $urandom_range(2, 24);
            endcase
            val = CFG_BITS'(nwin);
            if ($urandom_range(0, 1))
                val[CFG_BITS-1:WIN_BITS] = (CFG_BITS - WIN_BITS)'($urandom);
            write_reg(REG_WINDOW, val);
            if (nwin == 0)
                nwin = 1;

            count = nwin * ((nwin > 24) ? $urandom_range(1, 2) : $urandom_range(1, 6));
            if (nwin > 1 && $urandom_range(0, 3) == 0)
                count += $urandom_range(1, nwin - 1);
            repeat (count) send_sample(gen_sample());
            drain_block();
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
